// ===== hw/rtl/cbr_pkg.sv =====
// Shared types, constants and byte helpers for the CBC byte rotate cipher.
// No dependencies; imported by the transform, top-level and checker modules.
package cbr_pkg;

  localparam int unsigned CbrBlockBytes = 16;
  localparam int unsigned CbrPosW       = 4;
  localparam int unsigned CbrAmtW       = 3;
  localparam int unsigned CbrAddrW      = 6;
  localparam int unsigned CbrDataW      = 64;

  localparam logic [2:0] CbrRegKeyLow  = 3'd0;
  localparam logic [2:0] CbrRegKeyHigh = 3'd1;
  localparam logic [2:0] CbrRegIvLow   = 3'd2;
  localparam logic [2:0] CbrRegIvHigh  = 3'd3;
  localparam logic [2:0] CbrRegMode    = 3'd4;

  typedef enum logic {
    CbrStream,
    CbrPad
  } cbr_state_e;

  function automatic logic [7:0] cbr_rotl(input logic [7:0] v, input logic [CbrAmtW-1:0] s);
    logic [15:0] w;
    w = {v, v} << s;
    return w[15:8];
  endfunction

  function automatic logic [7:0] cbr_rotr(input logic [7:0] v, input logic [CbrAmtW-1:0] s);
    logic [15:0] w;
    w = {v, v} >> s;
    return w[7:0];
  endfunction

endpackage

// ===== hw/rtl/cbr_in_if.sv =====
// Input channel of the cipher: one message byte per request.
// No dependencies.
interface cbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

// ===== hw/rtl/cbr_out_if.sv =====
// Output channel of the cipher: one transformed byte per request.
// No dependencies.
interface cbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ===== hw/rtl/cbr_cell.sv =====
// One cell of the chain ring: holds a single chain byte.
// Depends on nothing; instantiated sixteen times by the top level.
module cbr_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       load_i,
  input  logic [7:0] load_val_i,
  input  logic [7:0] next_val_i,
  output logic [7:0] val_o
);

  logic [7:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (shift_i) begin
      val_d = load_i ? load_val_i : next_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 8'd0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// ===== hw/rtl/cbr_xform.sv =====
// Per-byte transform: xor with the chain byte and rotate by the key amount.
// Depends on cbr_pkg for the rotate helpers.
module cbr_xform
  import cbr_pkg::*;
(
  input  logic [7:0]         data_i,
  input  logic [7:0]         chain_i,
  input  logic [CbrAmtW-1:0] amt_i,
  input  logic               decrypt_i,
  output logic [7:0]         res_o,
  output logic [7:0]         chain_o
);

  always_comb begin
    if (decrypt_i) begin
      res_o   = cbr_rotr(data_i, amt_i) ^ chain_i;
      chain_o = data_i;
    end else begin
      res_o   = cbr_rotl(data_i ^ chain_i, amt_i);
      chain_o = res_o;
    end
  end

endmodule

// ===== hw/rtl/cbc_byte_rotate_cipher_core.sv =====
// Top level of the CBC byte rotate cipher: register port, chain ring and output skid.
// Depends on cbr_pkg, cbr_in_if, cbr_out_if, cbr_cell and cbr_xform.
//
//  channel | direction | carries
//  --------+-----------+-----------------------------------------------
//  in_i    | sink      | data_byte, final_byte; one message byte per request
//  out_o   | source    | out_byte, out_last; one result byte per request
//  APB     | slave     | key, IV and mode registers at byte address 8*i
//
// One input request is taken per cycle while the skid stage is empty; its result is
// registered the same cycle. A final byte that leaves its block short is followed by
// one padding byte per cycle (up to fifteen), skid permitting, with in_i.ready low.
// An output register with a skid stage keeps input taken while one result waits.
// Reset is asynchronous and active low; no clearing pass is needed.
module cbc_byte_rotate_cipher_core
  import cbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  cbr_in_if.sink              in_i,
  cbr_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CbrAddrW-1:0] paddr,
  input  logic [CbrDataW-1:0] pwdata,
  output logic [CbrDataW-1:0] prdata,
  output logic                pready
);

  // Configuration registers.
  logic [63:0] key_low_q, key_high_q, iv_low_q, iv_high_q;
  logic        decrypt_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CbrAddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      iv_low_q   <= '0;
      iv_high_q  <= '0;
      decrypt_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CbrRegKeyLow:  key_low_q  <= pwdata;
        CbrRegKeyHigh: key_high_q <= pwdata;
        CbrRegIvLow:   iv_low_q   <= pwdata;
        CbrRegIvHigh:  iv_high_q  <= pwdata;
        CbrRegMode:    decrypt_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CbrRegKeyLow:  prdata = key_low_q;
      CbrRegKeyHigh: prdata = key_high_q;
      CbrRegIvLow:   prdata = iv_low_q;
      CbrRegIvHigh:  prdata = iv_high_q;
      CbrRegMode:    prdata = {63'd0, decrypt_q};
      default:       prdata = '0;
    endcase
  end

  // Sequencer state.
  cbr_state_e         state_q, state_d;
  logic [CbrPosW-1:0] pos_q, pos_d, pos_next;
  logic               fresh_q, fresh_d;
  logic               step;
  logic               step_last;
  logic [7:0]         step_data;

  // Output register and skid stage.
  logic       out_valid_q, skid_valid_q;
  logic [7:0] out_byte_q, skid_byte_q;
  logic       out_last_q, skid_last_q;
  logic       space;

  assign space    = !skid_valid_q;
  assign pos_next = pos_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CbrStream: begin
        if (step && in_i.final_byte && (pos_next != '0)) begin
          state_d = CbrPad;
        end
      end
      CbrPad: begin
        if (step && (pos_next == '0)) begin
          state_d = CbrStream;
        end
      end
      default: state_d = CbrStream;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    step       = 1'b0;
    step_data  = 8'd0;
    step_last  = 1'b0;
    unique case (state_q)
      CbrStream: begin
        in_i.ready = space;
        step       = in_i.valid && space;
        step_data  = in_i.data_byte;
        step_last  = in_i.final_byte && (pos_next == '0);
      end
      CbrPad: begin
        step      = space;
        step_last = (pos_next == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    pos_d   = step ? pos_next : pos_q;
    fresh_d = fresh_q;
    if (step) begin
      fresh_d = step_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CbrStream;
      pos_q   <= '0;
      fresh_q <= 1'b1;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      fresh_q <= fresh_d;
    end
  end

  // Chain ring: cell 0 holds the current chain byte; a message's first byte uses the IV.
  logic [127:0]       key_all, iv_all;
  logic [7:0]         cell_val [CbrBlockBytes];
  logic [7:0]         chain_cur, chain_new, res;
  logic [CbrAmtW-1:0] amt;

  assign key_all   = {key_high_q, key_low_q};
  assign iv_all    = {iv_high_q, iv_low_q};
  assign amt       = key_all[{pos_q, 3'b000} +: CbrAmtW];
  assign chain_cur = fresh_q ? iv_all[7:0] : cell_val[0];

  for (genvar k = 0; k < CbrBlockBytes; k++) begin : g_cell
    logic [7:0] load_val, next_val;
    if (k == CbrBlockBytes - 1) begin : g_tail
      assign load_val = chain_new;
      assign next_val = chain_new;
    end else begin : g_body
      assign load_val = iv_all[8*(k+1) +: 8];
      assign next_val = cell_val[k+1];
    end
    cbr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (step),
      .load_i     (fresh_q),
      .load_val_i (load_val),
      .next_val_i (next_val),
      .val_o      (cell_val[k])
    );
  end

  cbr_xform u_xform (
    .data_i    (step_data),
    .chain_i   (chain_cur),
    .amt_i     (amt),
    .decrypt_i (decrypt_q),
    .res_o     (res),
    .chain_o   (chain_new)
  );

  // A request enters the skid only when the output register is full and not leaving.
  logic pop;
  assign pop = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        out_valid_q  <= skid_valid_q || step;
        skid_valid_q <= 1'b0;
      end else if (step) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_byte_q <= skid_byte_q;
        out_last_q <= skid_last_q;
      end else if (step) begin
        out_byte_q <= res;
        out_last_q <= step_last;
      end
    end else if (step) begin
      skid_byte_q <= res;
      skid_last_q <= step_last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

endmodule

// ===== hw/rtl/cbr_checker.sv =====
// Port-level checker for the cipher core, bound to every instance of the top level.
// Depends on cbr_pkg and cbc_byte_rotate_cipher_core.
module cbr_checker
  import cbr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_final,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic [CbrPosW-1:0] in_pos_q, out_pos_q;
  logic               in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      out_pos_q <= '0;
    end else begin
      if (in_acc) begin
        in_pos_q <= in_final ? '0 : in_pos_q + 1'b1;
      end
      if (out_acc) begin
        out_pos_q <= out_last ? '0 : out_pos_q + 1'b1;
      end
    end
  end

  // A padded message always ends on a block boundary.
  a_last_on_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last |-> out_pos_q == 4'd15)
    else $error("message end request not at the last byte of a block");

  // A short final block holds off input while padding is produced.
  a_pad_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_final && (in_pos_q != 4'd15) |=> !in_ready)
    else $error("input taken while padding should be in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output request changed");

endmodule

bind cbc_byte_rotate_cipher_core cbr_checker u_cbr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_final  (in_i.final_byte),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_byte  (out_o.out_byte),
  .out_last  (out_o.out_last)
);
